// ===== hdl/bba_pkg.sv =====
// bba_pkg: shared types and constants of the bitmap block allocator
// no dependencies; imported by bba_div, bba_map, bitmap_block_allocator_top and the testbench
`default_nettype none

package bba_pkg;

	// request kinds carried on s_tuser
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// fixed field widths
	localparam int INDEX_W    = 16;   // block_index
	localparam int GRANT_W    = 15;   // granted_index
	localparam int START_W    = 15;   // first_allocatable
	localparam int DIVIDEND_W = 16;   // width of a value split into word and bit offset
	localparam int IDX_EXT_W  = 17;   // block index with headroom past the last word

	// status of the word/offset divider
	typedef struct packed {
		logic busy;
		logic done;
	} bba_div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/bba_div.sv =====
// bba_div: word and bit offset of a block index by reciprocal multiplication
// depends on bba_pkg
`default_nettype none

module bba_div #(
	parameter int DIVISOR = 32,
	parameter int QUO_W   = 10,
	parameter int REM_W   = 5
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [bba_pkg::DIVIDEND_W-1:0]     dividend,
	output bba_pkg::bba_div_stat_t                  stat,
	output logic      [QUO_W-1:0]                   quotient,
	output logic      [REM_W-1:0]                   remainder
);
	import bba_pkg::*;

	// exact for every dividend below 2**DIVIDEND_W with a shift of DIVIDEND_W + ceil(log2(DIVISOR))
	localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
	localparam int RECIP_W = DIVIDEND_W + 1;
	localparam int PROD_W  = DIVIDEND_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR));
	localparam logic [DIVIDEND_W-1:0] DIV_C = DIVIDEND_W'(DIVISOR);

	logic [DIVIDEND_W-1:0] dvd_s1;
	logic [DIVIDEND_W-1:0] dvd_s2;
	logic [QUO_W-1:0]      quo_s2;
	logic [REM_W-1:0]      rem_q;
	logic                  vld_s1;
	logic                  vld_s2;
	logic                  done_q;
	logic [PROD_W-1:0]     prod;
	logic [DIVIDEND_W-1:0] quo_ext;
	logic [DIVIDEND_W-1:0] back;

	// quotient from the scaled reciprocal, remainder by multiplying back
	assign prod    = {{RECIP_W{1'b0}}, dvd_s1} * {{DIVIDEND_W{1'b0}}, RECIP};
	assign quo_ext = DIVIDEND_W'(prod >> SHIFT);
	assign back    = DIVIDEND_W'(quo_s2) * DIV_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_s1 <= dividend;
		end
		if (vld_s1) begin
			dvd_s2 <= dvd_s1;
			quo_s2 <= quo_ext[QUO_W-1:0];
		end
		if (vld_s2) begin
			rem_q <= REM_W'(dvd_s2 - back);
		end
	end

	assign stat.busy = vld_s1 || vld_s2;
	assign stat.done = done_q;
	assign quotient  = quo_s2;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hdl/bba_map.sv =====
// bba_map: used/free bitmap memory, one write and one registered read port
// depends on bba_pkg
`default_nettype none

module bba_map #(
	parameter int WORDS  = 1024,
	parameter int WORD_W = 32,
	parameter int AW     = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [WORD_W-1:0] rdata
);
	import bba_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bitmap_block_allocator_top.sv =====
// bitmap_block_allocator_top: first-fit block allocator over a flat used/free bitmap memory
// depends on bba_pkg, bba_div, bba_map
// a free is split into word and bit offset, its word read and written back, then presented; an
//   allocate reads bitmap words from the start word on until a clear bit or the last word; a
//   rejected request goes straight to the result; one transaction at a time, and the next is
//   taken while a result waits on the master side
// reset: arst_n clears control; a clearing pass then zeroes the bitmap one word a cycle
//   while s_tready stays low; first_allocatable resets to 1
`default_nettype none

module bitmap_block_allocator_top #(
	parameter int BLOCK_COUNT   = 32768,
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request side
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [bba_pkg::INDEX_W-1:0]        s_tdata,   // [15:0] block_index
	input  wire logic                               s_tuser,   // [0] kind
	// result side
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [15:0]                        m_tdata,   // [14:0] granted_index, [15] zero
	output logic                                    m_tuser,   // [0] found
	// start register
	input  wire logic                               cfg_we,
	input  wire logic [bba_pkg::START_W-1:0]        cfg_wdata
);
	import bba_pkg::*;

	localparam int MAP_WORDS = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int OFF_W     = $clog2(MAP_WORD_BITS);
	// number of real blocks held in the last bitmap word
	localparam int LAST_BITS = BLOCK_COUNT - (MAP_WORDS - 1) * MAP_WORD_BITS;
	localparam logic [WA_W-1:0]      LAST_WORD = WA_W'(MAP_WORDS - 1);
	localparam logic [IDX_EXT_W-1:0] BC_EXT    = IDX_EXT_W'(BLOCK_COUNT);
	localparam logic [IDX_EXT_W-1:0] STEP_EXT  = IDX_EXT_W'(MAP_WORD_BITS);

	// controller states
	localparam logic [2:0] ST_CLR  = 3'd0;  // clearing pass after reset
	localparam logic [2:0] ST_IDLE = 3'd1;  // waiting for a request
	localparam logic [2:0] ST_DIV  = 3'd2;  // splitting index into word and bit offset
	localparam logic [2:0] ST_FWR  = 3'd3;  // free: write back word with bit cleared
	localparam logic [2:0] ST_SCAN = 3'd4;  // allocate: stream words and look for a clear bit
	localparam logic [2:0] ST_DONE = 3'd5;  // hand the result to the output register

	logic [2:0]             state_q;
	logic [WA_W-1:0]        clr_addr_q;
	logic [START_W-1:0]     fa_q;
	logic                   kind_q;
	logic [DIVIDEND_W-1:0]  dvd_q;

	// scan issue side
	logic [WA_W-1:0]        addr_q;
	logic [IDX_EXT_W-1:0]   base_q;
	logic [OFF_W-1:0]       off_q;
	logic                   first_q;
	logic                   issue_q;

	// scan evaluate side, registered in step with the read data
	logic                   valid_s1;
	logic [WA_W-1:0]        addr_s1;
	logic [IDX_EXT_W-1:0]   base_s1;
	logic                   first_s1;
	logic                   last_s1;

	// pending result and output register
	logic [GRANT_W-1:0]     res_grant_q;
	logic                   res_found_q;
	logic                   m_tvalid_q;
	logic [15:0]            m_tdata_q;
	logic                   m_tuser_q;

	// divider
	logic                   div_start;
	logic [DIVIDEND_W-1:0]  div_dividend;
	bba_div_stat_t          div_stat;
	logic [WA_W-1:0]        div_quo;
	logic [OFF_W-1:0]       div_rem;

	// bitmap port
	logic                     mem_we;
	logic [WA_W-1:0]          mem_waddr;
	logic [MAP_WORD_BITS-1:0] mem_wdata;
	logic                     mem_re;
	logic [WA_W-1:0]          mem_raddr;
	logic [MAP_WORD_BITS-1:0] mem_rdata;

	// search over the returned word
	logic [MAP_WORD_BITS-1:0] free_bits;
	logic [MAP_WORD_BITS-1:0] off_onehot;
	logic [MAP_WORD_BITS-1:0] pos_onehot;
	logic [OFF_W-1:0]         pos;
	logic                     any_free;
	logic                     stop;
	logic [IDX_EXT_W-1:0]     grant_sum;

	logic                   s_accept;
	logic                   req_in_range;
	logic                   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// out-of-range checks done at accept time, before any memory work
	always_comb begin
		if (s_tuser == KIND_FREE) begin
			req_in_range = ({1'b0, s_tdata} < BC_EXT);
			div_dividend = s_tdata;
		end else begin
			req_in_range = ({2'b0, fa_q} < BC_EXT);
			div_dividend = {1'b0, fa_q};
		end
	end

	assign div_start = s_accept && req_in_range;

	bba_div #(
		.DIVISOR (MAP_WORD_BITS),
		.QUO_W   (WA_W),
		.REM_W   (OFF_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// free bits of the word under evaluation: bits below the start offset are skipped
	// in the first word, bits past the last block are skipped in the last word
	always_comb begin
		for (int k = 0; k < MAP_WORD_BITS; k++) begin
			free_bits[k] = !mem_rdata[k]
				&& !(first_s1 && (k < int'(off_q)))
				&& !(last_s1 && (k >= LAST_BITS));
		end
	end

	// lowest clear bit wins
	always_comb begin
		pos = '0;
		for (int k = MAP_WORD_BITS - 1; k >= 0; k--) begin
			if (free_bits[k]) begin
				pos = OFF_W'(k);
			end
		end
	end

	assign any_free   = |free_bits;
	assign stop       = valid_s1 && (any_free || last_s1);
	assign off_onehot = {{(MAP_WORD_BITS - 1){1'b0}}, 1'b1} << off_q;
	assign pos_onehot = {{(MAP_WORD_BITS - 1){1'b0}}, 1'b1} << pos;
	assign grant_sum  = base_s1 + IDX_EXT_W'(pos);

	// bitmap write port: clearing pass, free write-back, allocate write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = mem_rdata & ~off_onehot;
		priority if (state_q == ST_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (state_q == ST_FWR) begin
			mem_we    = 1'b1;
		end else if (state_q == ST_SCAN && valid_s1 && any_free) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = mem_rdata | pos_onehot;
		end else begin
			mem_we    = 1'b0;
		end
	end

	// read port: the free read follows the divider, the scan reads one word a cycle
	assign mem_re    = (state_q == ST_DIV && div_stat.done && kind_q == KIND_FREE)
		|| (state_q == ST_SCAN && issue_q);
	assign mem_raddr = (state_q == ST_SCAN) ? addr_q : div_quo;

	bba_map #(
		.WORDS  (MAP_WORDS),
		.WORD_W (MAP_WORD_BITS),
		.AW     (WA_W)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// start register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_q <= START_W'(1);
		end else if (cfg_we) begin
			fa_q <= cfg_wdata;
		end
	end

	// main controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_addr_q <= '0;
			issue_q    <= 1'b0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN) && issue_q && !stop;
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= req_in_range ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						issue_q <= (kind_q == KIND_ALLOC);
						state_q <= (kind_q == KIND_FREE) ? ST_FWR : ST_SCAN;
					end
				end
				ST_FWR: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (issue_q && (addr_q == LAST_WORD || stop)) begin
						issue_q <= 1'b0;
					end
					if (stop) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_q      <= s_tuser;
			dvd_q       <= div_dividend;
			// failure result for requests rejected at accept time
			res_grant_q <= '0;
			res_found_q <= 1'b0;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			addr_q  <= div_quo;
			off_q   <= div_rem;
			base_q  <= {1'b0, dvd_q} - IDX_EXT_W'(div_rem);
			first_q <= 1'b1;
		end else if (state_q == ST_SCAN && issue_q) begin
			addr_q  <= addr_q + 1'b1;
			base_q  <= base_q + STEP_EXT;
			first_q <= 1'b0;
		end
		addr_s1  <= addr_q;
		base_s1  <= base_q;
		first_s1 <= first_q;
		last_s1  <= (addr_q == LAST_WORD);
		if (state_q == ST_FWR) begin
			res_grant_q <= '0;
			res_found_q <= 1'b1;
		end else if (state_q == ST_SCAN && stop) begin
			res_grant_q <= any_free ? grant_sum[GRANT_W-1:0] : '0;
			res_found_q <= any_free;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {1'b0, res_grant_q};
			m_tuser_q <= res_found_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// the divider only runs for an accepted in-range request
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
		else $error("divider active outside the divide state");

	// a word under evaluation belongs to the running scan
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN))
		else $error("scan stage valid outside the scan state");

	// the bitmap is never written while waiting for a request or handing over a result
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !mem_we)
		else $error("bitmap write while idle");

	// a free result never carries a block index
	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && kind_q == KIND_FREE) |-> (res_grant_q == '0))
		else $error("free transaction with nonzero granted index");

endmodule

`default_nettype wire

// ===== verif/tb_bitmap_block_allocator_top.sv =====
// tb_bitmap_block_allocator_top: self-checking bench for the first-fit bitmap block allocator
// depends on bba_pkg and bitmap_block_allocator_top; a scoreboard class mirrors the bitmap
// and checks each result transaction against the oldest predicted grant or free ack
`default_nettype none

module tb_bitmap_block_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int          BLOCKS      = 32768;
	localparam int          MAP_BITS    = 32;
	localparam int          CFG_HOLD    = 32;         // idle margin before a start register write
	localparam int          END_WAIT    = 64;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;  // watchdog limit on bench cycles

	// one predicted result transaction
	typedef struct packed {
		logic [GRANT_W-1:0] granted;
		logic               found;
	} grant_t;

	// shadow of the used/free bitmap plus the queue of pending results
	class alloc_scoreboard;
		bit             used_map [BLOCKS];
		bit [START_W-1:0] first_free;
		grant_t         awaited [$];
		int             errors, n_alloc, n_free, n_grant, n_refused, n_starts;

		function new();
			foreach (used_map[i])
				used_map[i] = 1'b0;
			first_free = START_W'(1);
		endfunction

		function void set_start(bit [START_W-1:0] v);
			first_free = v;
			n_starts++;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// first-fit search or free of one accepted request
		function grant_t note_request(logic kind, logic [INDEX_W-1:0] idx);
			grant_t r;
			int     blk;
			r = '0;
			if (kind == KIND_ALLOC) begin
				n_alloc++;
				for (blk = first_free; blk < BLOCKS; blk++) begin
					if (!used_map[blk]) begin
						used_map[blk] = 1'b1;
						r.granted = blk[GRANT_W-1:0];
						r.found = 1'b1;
						break;
					end
				end
				if (r.found)
					n_grant++;
				else
					n_refused++;
			end else begin
				n_free++;
				if (idx < BLOCKS) begin
					used_map[idx] = 1'b0;
					r.found = 1'b1;
				end
			end
			awaited.push_back(r);
			return r;
		endfunction

		function void check_result(logic [GRANT_W-1:0] granted, logic found);
			grant_t e;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual granted %0d found %0d",
					$time, granted, found);
				return;
			end
			e = awaited.pop_front();
			if (granted !== e.granted) begin
				errors++;
				$display("%0t granted_index mismatch: expected %0d actual %0d",
					$time, e.granted, granted);
			end
			if (found !== e.found) begin
				errors++;
				$display("%0t found mismatch: expected %0d actual %0d", $time, e.found, found);
			end
		endfunction
	endclass

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	// dut-facing signals; the ones the bench drives are known from time zero
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [INDEX_W-1:0]  s_tdata   = '0;  // [15:0] block_index
	logic                s_tuser   = 1'b0;  // [0] kind
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [15:0]         m_tdata;  // [14:0] granted_index, [15] zero
	logic                m_tuser;  // [0] found
	logic                cfg_we    = 1'b0;
	logic [START_W-1:0]  cfg_wdata = '0;

	alloc_scoreboard sb = new();

	int unsigned live_blocks [$];  // indices handed out and not yet freed by the bench, candidates for frees
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int unsigned cycles = 0;

	bitmap_block_allocator_top #(
		.BLOCK_COUNT   (BLOCKS),
		.MAP_WORD_BITS (MAP_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result monitor: values read here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[GRANT_W-1:0], m_tuser);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t watchdog expired with %0d results pending", $time, sb.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// one request transaction; valid stays up afterwards unless the next call idles first
	task automatic send_request(input logic kind, input logic [INDEX_W-1:0] idx);
		grant_t r;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		// allocate ignores the index, so fill it with noise
		s_tdata  <= (kind == KIND_ALLOC) ? INDEX_W'($urandom) : idx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = sb.note_request(kind, idx);
		if (kind == KIND_ALLOC && r.found)
			live_blocks.push_back(32'(r.granted));
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// start register write, only with the block idle
	task automatic write_start(input logic [START_W-1:0] v);
		wait_drained();
		repeat (CFG_HOLD) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_start(v);
	endtask

	// mostly alloc/free traffic on live blocks, plus stray and out-of-range frees
	task automatic random_request();
		int          roll;
		int unsigned k;
		logic [INDEX_W-1:0] idx;
		roll = $urandom_range(99);
		if (roll < 45) begin
			send_request(KIND_ALLOC, '0);
		end else if (roll < 80 && live_blocks.size() > 0) begin
			k   = $urandom_range(live_blocks.size() - 1);
			idx = INDEX_W'(live_blocks[k]);
			live_blocks.delete(k);
			send_request(KIND_FREE, idx);
		end else if (roll < 90) begin
			send_request(KIND_FREE, INDEX_W'($urandom_range(0, BLOCKS - 1)));
		end else begin
			send_request(KIND_FREE, INDEX_W'($urandom_range(BLOCKS, 65535)));
		end
	endtask

	task automatic random_phase(input int n, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n) random_request();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset holds s_tready low, the handshake wait covers it

		// directed: start at its reset value of 1
		rx_idle_pct = 20;
		send_request(KIND_ALLOC, '0);         // lowest block past metadata
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, '0);
		send_request(KIND_FREE, 16'd2);       // punch a hole
		send_request(KIND_ALLOC, '0);         // first fit refills the hole
		send_request(KIND_FREE, 16'hFFFF);    // out of range, every index bit set
		send_request(KIND_FREE, 16'h8000);    // first index past the last block
		send_request(KIND_FREE, 16'd0);       // below the start, already free
		send_request(KIND_FREE, 16'h7FFF);    // last block, never used
		send_request(KIND_FREE, 16'd5);       // free of a free block

		// start of zero lets block 0 be granted
		write_start('0);
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, '0);

		// top start: one block available, then full
		write_start(START_W'(BLOCKS - 1));
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, '0);
		send_request(KIND_FREE, 16'h7FFF);
		send_request(KIND_ALLOC, '0);

		// fill the tail then run into a full bitmap
		write_start(START_W'(BLOCKS - 8));
		repeat (8) send_request(KIND_ALLOC, '0);

		// random traffic under three stall patterns
		write_start(START_W'(1));
		random_phase(75, 38, 48);
		wait_drained();                       // sender holds off until all results are back
		random_phase(75, 38, 48);

		write_start(START_W'($urandom_range(2, 300)));
		random_phase(150, 48, 38);

		// start near the top so refusals show up among the grants
		write_start(START_W'($urandom_range(BLOCKS - 68, BLOCKS - 18)));
		random_phase(130, 0, 0);

		wait_drained();
		repeat (END_WAIT) @(posedge clk);

		$display("covered %0d allocates (%0d granted, %0d refused) and %0d frees",
			sb.n_alloc, sb.n_grant, sb.n_refused, sb.n_free);
		$display("over %0d start register settings and three back-pressure patterns",
			sb.n_starts + 1);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
